// ===== src/kpcalc_pkg.sv =====
// Shared types, constants and key codes for the keypad calculator.
package kpcalc_pkg;

  localparam int KEY_W     = 8;
  localparam int DIGIT_W   = 4;
  localparam int OPERAND_W = 30;
  localparam int WHOLE_W   = 61;
  localparam int FRAC_W    = 16;
  localparam int ADD_W     = 32;
  localparam int DIGIT_SUM_W = OPERAND_W + 4;

  localparam logic [OPERAND_W-1:0] MAX_OPERAND = OPERAND_W'(999999999);
  localparam int DEF_FRAC_BITS = 16;

  localparam logic [KEY_W-1:0] KEY_CLEAR  = 8'h3F;  // '?'
  localparam logic [KEY_W-1:0] KEY_EQUALS = 8'h3D;  // '='
  localparam logic [KEY_W-1:0] KEY_ZERO   = 8'h30;  // '0'
  localparam logic [KEY_W-1:0] KEY_NINE   = 8'h39;  // '9'
  localparam logic [KEY_W-1:0] KEY_PLUS   = 8'h2B;  // '+'
  localparam logic [KEY_W-1:0] KEY_MINUS  = 8'h2D;  // '-'
  localparam logic [KEY_W-1:0] KEY_TIMES  = 8'h2A;  // '*'
  localparam logic [KEY_W-1:0] KEY_DIVIDE = 8'h2F;  // '/'

  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_PLUS   = 3'd1,
    OP_MINUS  = 3'd2,
    OP_TIMES  = 3'd3,
    OP_DIVIDE = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    KIND_IGNORED = 3'd0,
    KIND_ECHO    = 3'd1,
    KIND_CLEARED = 3'd2,
    KIND_RESULT  = 3'd3,
    KIND_DIVZERO = 3'd4
  } kind_t;

  typedef enum logic [0:0] {
    TS_IDLE,
    TS_BUSY
  } top_state_t;

  typedef enum logic [1:0] {
    AS_IDLE,
    AS_MUL,
    AS_DIV
  } alu_state_t;

  typedef struct packed {
    logic                 start;
    op_t                  op;
    logic [OPERAND_W-1:0] a;
    logic [OPERAND_W-1:0] b;
  } alu_cmd_t;

  typedef struct packed {
    logic                      done;
    logic signed [WHOLE_W-1:0] whole;
    logic [FRAC_W-1:0]         frac;
  } alu_rsp_t;

endpackage

// ===== src/kpcalc_ifs.sv =====
// Valid/ready channel interfaces for key beats and event beats.
interface kpcalc_key_if;
  import kpcalc_pkg::*;

  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_code;

  modport source (output valid, output key_code, input ready);
  modport sink   (input valid, input key_code, output ready);
endinterface

interface kpcalc_evt_if;
  import kpcalc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [2:0]                event_kind;
  logic [KEY_W-1:0]          echo_char;
  logic signed [WHOLE_W-1:0] result_whole;
  logic [FRAC_W-1:0]         result_fraction;

  modport source (output valid, output event_kind, output echo_char,
                  output result_whole, output result_fraction, input ready);
  modport sink   (input valid, input event_kind, input echo_char,
                  input result_whole, input result_fraction, output ready);
endinterface

// ===== src/kpcalc_digit.sv =====
// Decimal digit append: operand times ten plus digit, saturated.
module kpcalc_digit (
  input  logic [kpcalc_pkg::OPERAND_W-1:0] operand,
  input  logic [kpcalc_pkg::DIGIT_W-1:0]   digit,
  output logic [kpcalc_pkg::OPERAND_W-1:0] extended
);
  import kpcalc_pkg::*;

  logic [DIGIT_SUM_W-1:0] wide;

  // times ten as times eight plus times two
  assign wide = (DIGIT_SUM_W'(operand) << 3) + (DIGIT_SUM_W'(operand) << 1)
              + DIGIT_SUM_W'(digit);

  assign extended = (wide > DIGIT_SUM_W'(MAX_OPERAND)) ? MAX_OPERAND
                                                       : wide[OPERAND_W-1:0];
endmodule

// ===== src/kpcalc_alu.sv =====
// Shared add/subtract unit sequenced for sums, shift-add multiply and restoring divide.
module kpcalc_alu #(
  parameter int FRAC_BITS = kpcalc_pkg::DEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  kpcalc_pkg::alu_cmd_t cmd,
  output kpcalc_pkg::alu_rsp_t rsp
);
  import kpcalc_pkg::*;

  localparam int LW = OPERAND_W + FRAC_BITS;
  localparam int CW = $clog2(LW);
  localparam logic [CW-1:0] MUL_LAST = CW'(OPERAND_W - 1);
  localparam logic [CW-1:0] DIV_LAST = CW'(LW - 1);

  alu_state_t state, state_next;

  logic [OPERAND_W:0]        hi, hi_next;
  logic [LW-1:0]             lo, lo_next;
  logic [CW-1:0]             count, count_next;
  logic                      done, done_next;
  logic signed [WHOLE_W-1:0] whole, whole_next;
  logic [FRAC_W-1:0]         frac, frac_next;

  // the one shared adder
  logic [ADD_W-1:0] add_x, add_y, add_sum;
  logic             add_sub;
  logic [OPERAND_W:0] div_trial;
  logic               div_ge;

  assign add_sum = add_x + (add_sub ? ~add_y : add_y) + ADD_W'(add_sub);

  assign div_trial = {hi[OPERAND_W-1:0], lo[LW-1]};
  assign div_ge    = !add_sum[ADD_W-1];

  always_comb begin
    state_next = state;
    hi_next    = hi;
    lo_next    = lo;
    count_next = count;
    done_next  = 1'b0;
    whole_next = whole;
    frac_next  = frac;
    add_x      = ADD_W'(cmd.a);
    add_y      = ADD_W'(cmd.b);
    add_sub    = 1'b0;
    case (state)
      AS_IDLE: begin
        add_sub = (cmd.op == OP_MINUS);
        if (cmd.start) begin
          case (cmd.op)
            OP_PLUS, OP_MINUS: begin
              done_next  = 1'b1;
              whole_next = {{(WHOLE_W-ADD_W){add_sum[ADD_W-1]}}, add_sum};
              frac_next  = '0;
            end
            OP_TIMES: begin
              hi_next    = '0;
              lo_next    = LW'(cmd.b);
              count_next = '0;
              state_next = AS_MUL;
            end
            OP_DIVIDE: begin
              hi_next    = '0;
              lo_next    = {cmd.a, {FRAC_BITS{1'b0}}};
              count_next = '0;
              state_next = AS_DIV;
            end
            default: begin
              done_next = 1'b0;
            end
          endcase
        end
      end
      AS_MUL: begin
        // add multiplicand when the low multiplier bit is set, then shift right
        add_x      = ADD_W'(hi);
        add_y      = lo[0] ? ADD_W'(cmd.a) : '0;
        hi_next    = add_sum[ADD_W-1:1];
        lo_next    = {lo[LW-1:OPERAND_W], add_sum[0], lo[OPERAND_W-1:1]};
        count_next = count + 1'b1;
        if (count == MUL_LAST) begin
          state_next = AS_IDLE;
          done_next  = 1'b1;
          whole_next = WHOLE_W'({hi_next[OPERAND_W-1:0], lo_next[OPERAND_W-1:0]});
          frac_next  = '0;
        end
      end
      AS_DIV: begin
        // trial subtract; keep the difference when it does not borrow
        add_x      = ADD_W'(div_trial);
        add_y      = ADD_W'(cmd.b);
        add_sub    = 1'b1;
        hi_next    = div_ge ? (OPERAND_W+1)'(add_sum[OPERAND_W-1:0])
                            : (OPERAND_W+1)'(div_trial[OPERAND_W-1:0]);
        lo_next    = {lo[LW-2:0], div_ge};
        count_next = count + 1'b1;
        if (count == DIV_LAST) begin
          state_next = AS_IDLE;
          done_next  = 1'b1;
          whole_next = WHOLE_W'(lo_next[LW-1:FRAC_BITS]);
          frac_next  = FRAC_W'(lo_next[FRAC_BITS-1:0]);
        end
      end
      default: begin
        state_next = AS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= AS_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    hi    <= hi_next;
    lo    <= lo_next;
    count <= count_next;
    whole <= whole_next;
    frac  <= frac_next;
  end

  assign rsp.done  = done;
  assign rsp.whole = whole;
  assign rsp.frac  = frac;
endmodule

// ===== src/keypad_four_function_calculator.sv =====
// Top level of the keypad calculator: key decode, operand registers, sequencer, output register.
// One key beat in gives exactly one event beat out. Digit, operator, clear and
// unknown keys, and '=' with no operator or with a zero divisor, are written
// straight into the output register, and the sequencer stays idle.
// '=' with plus or minus makes one pass through the shared adder, with times
// 30 shift-add steps of it, one per multiplier bit, and with divide
// 30 + FRAC_BITS restoring-divide steps on the same adder, one per quotient bit.
// All evaluation arithmetic runs through that one 32-bit adder in the ALU;
// keys are not taken while it works. The output register holds an event
// until the sink takes it, and a new key is taken in the same cycle as that
// beat leaves. Quotients carry FRAC_BITS fraction bits, truncated, returned
// right-aligned in result_fraction.
module keypad_four_function_calculator #(
  parameter int FRAC_BITS = kpcalc_pkg::DEF_FRAC_BITS
) (
  input  logic         clk,
  input  logic         rst,
  kpcalc_key_if.sink   keys,
  kpcalc_evt_if.source results
);
  import kpcalc_pkg::*;

  top_state_t state, state_next;

  // calculator state
  logic                      phase, phase_next;
  logic [OPERAND_W-1:0]      op_a, op_a_next;
  logic [OPERAND_W-1:0]      op_b, op_b_next;
  op_t                       pend, pend_next;
  logic signed [WHOLE_W-1:0] last_whole, last_whole_next;
  logic [FRAC_W-1:0]         last_frac, last_frac_next;

  // output register
  logic                      ovalid, ovalid_next;
  kind_t                     okind, okind_next;
  logic [KEY_W-1:0]          ochar, ochar_next;
  logic signed [WHOLE_W-1:0] owhole, owhole_next;
  logic [FRAC_W-1:0]         ofrac, ofrac_next;

  logic                 accept;
  logic                 is_digit;
  logic                 is_oper;
  logic [DIGIT_W-1:0]   digit;
  logic [OPERAND_W-1:0] digit_in, digit_out;
  alu_cmd_t             alu_cmd;
  alu_rsp_t             alu_rsp;

  // take a key only when idle and the output slot is free or draining now
  assign keys.ready = (state == TS_IDLE) && (!ovalid || results.ready);
  assign accept     = keys.valid && keys.ready;

  assign is_digit = (keys.key_code >= KEY_ZERO) && (keys.key_code <= KEY_NINE);
  assign is_oper  = (keys.key_code == KEY_PLUS) || (keys.key_code == KEY_MINUS) ||
                    (keys.key_code == KEY_TIMES) || (keys.key_code == KEY_DIVIDE);
  assign digit    = DIGIT_W'(keys.key_code - KEY_ZERO);
  assign digit_in = phase ? op_b : op_a;

  kpcalc_digit u_digit (
    .operand  (digit_in),
    .digit    (digit),
    .extended (digit_out)
  );

  kpcalc_alu #(
    .FRAC_BITS (FRAC_BITS)
  ) u_alu (
    .clk (clk),
    .rst (rst),
    .cmd (alu_cmd),
    .rsp (alu_rsp)
  );

  always_comb begin
    state_next      = state;
    phase_next      = phase;
    op_a_next       = op_a;
    op_b_next       = op_b;
    pend_next       = pend;
    last_whole_next = last_whole;
    last_frac_next  = last_frac;
    // drop the held beat once the sink takes it
    ovalid_next     = ovalid && !results.ready;
    okind_next      = okind;
    ochar_next      = ochar;
    owhole_next     = owhole;
    ofrac_next      = ofrac;
    alu_cmd.start   = 1'b0;
    alu_cmd.op      = pend;
    alu_cmd.a       = op_a;
    alu_cmd.b       = op_b;
    case (state)
      TS_IDLE: begin
        if (accept) begin
          ovalid_next = 1'b1;
          okind_next  = KIND_IGNORED;
          ochar_next  = '0;
          owhole_next = '0;
          ofrac_next  = '0;
          if (keys.key_code == KEY_CLEAR) begin
            phase_next      = 1'b0;
            op_a_next       = '0;
            op_b_next       = '0;
            pend_next       = OP_NONE;
            last_whole_next = '0;
            last_frac_next  = '0;
            okind_next      = KIND_CLEARED;
          end else if (is_digit) begin
            if (phase) begin
              op_b_next = digit_out;
            end else begin
              op_a_next = digit_out;
            end
            okind_next = KIND_ECHO;
            ochar_next = keys.key_code;
          end else if (is_oper) begin
            case (keys.key_code)
              KEY_PLUS:  pend_next = OP_PLUS;
              KEY_MINUS: pend_next = OP_MINUS;
              KEY_TIMES: pend_next = OP_TIMES;
              default:   pend_next = OP_DIVIDE;
            endcase
            phase_next = 1'b1;
            okind_next = KIND_ECHO;
            ochar_next = keys.key_code;
          end else if (keys.key_code == KEY_EQUALS) begin
            if (pend == OP_NONE) begin
              // repeat the last result
              okind_next  = KIND_RESULT;
              owhole_next = last_whole;
              ofrac_next  = last_frac;
            end else if ((pend == OP_DIVIDE) && (op_b == '0)) begin
              okind_next = KIND_DIVZERO;
            end else begin
              // hold the output slot empty until the ALU answers
              ovalid_next   = 1'b0;
              alu_cmd.start = 1'b1;
              state_next    = TS_BUSY;
            end
          end
        end
      end
      TS_BUSY: begin
        if (alu_rsp.done) begin
          last_whole_next = alu_rsp.whole;
          last_frac_next  = alu_rsp.frac;
          ovalid_next     = 1'b1;
          okind_next      = KIND_RESULT;
          ochar_next      = '0;
          owhole_next     = alu_rsp.whole;
          ofrac_next      = alu_rsp.frac;
          state_next      = TS_IDLE;
        end
      end
      default: begin
        state_next = TS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= TS_IDLE;
      ovalid     <= 1'b0;
      phase      <= 1'b0;
      op_a       <= '0;
      op_b       <= '0;
      pend       <= OP_NONE;
      last_whole <= '0;
      last_frac  <= '0;
    end else begin
      state      <= state_next;
      ovalid     <= ovalid_next;
      phase      <= phase_next;
      op_a       <= op_a_next;
      op_b       <= op_b_next;
      pend       <= pend_next;
      last_whole <= last_whole_next;
      last_frac  <= last_frac_next;
    end
  end

  always_ff @(posedge clk) begin
    okind  <= okind_next;
    ochar  <= ochar_next;
    owhole <= owhole_next;
    ofrac  <= ofrac_next;
  end

  assign results.valid           = ovalid;
  assign results.event_kind      = okind;
  assign results.echo_char       = ochar;
  assign results.result_whole    = owhole;
  assign results.result_fraction = ofrac;

  // a zero divisor at '=' must report the error on the next beat
  a_divzero: assert property (@(posedge clk) disable iff (rst)
    accept && (keys.key_code == KEY_EQUALS) && (pend == OP_DIVIDE) && (op_b == '0)
    |=> ovalid && (okind == KIND_DIVZERO))
    else $error("divide by zero not reported");

  // the ALU answers only while the sequencer waits for it
  a_alu_done: assert property (@(posedge clk) disable iff (rst)
    alu_rsp.done |-> (state == TS_BUSY))
    else $error("ALU done outside busy state");

  // saturation keeps both operands in range
  a_operand_range: assert property (@(posedge clk) disable iff (rst)
    (op_a <= MAX_OPERAND) && (op_b <= MAX_OPERAND))
    else $error("operand above maximum");

  // only result events carry numeric payload
  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    ovalid && (okind != KIND_RESULT) |-> (owhole == '0) && (ofrac == '0))
    else $error("non-result event carries a value");
endmodule
